// ===== design/meter_teleinfo_line_checker_top_defines.svh =====
// Assertion macros shared by the line checker RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef METER_TELEINFO_LINE_CHECKER_TOP_DEFINES_SVH
`define METER_TELEINFO_LINE_CHECKER_TOP_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication under reset gating.
`define MTLC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("line checker assertion failed");
// Next-cycle implication under reset gating.
`define MTLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("line checker assertion failed");
`else
`define MTLC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define MTLC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/mtlc_pkg.sv =====
// Shared types and constants of the line checker.
// No dependencies; used by every module.
package mtlc_pkg;

	localparam int DEF_LINE_CAPACITY = 256;

	localparam logic [6:0] CHAR_MASK = 7'h7F;
	localparam logic [6:0] CH_STX    = 7'h02;
	localparam logic [6:0] CH_ETX    = 7'h03;
	localparam logic [6:0] CH_LF     = 7'h0A;
	localparam logic [6:0] CH_CR     = 7'h0D;
	localparam logic [6:0] CH_TAB    = 7'h09;

	localparam logic [5:0] CHK_MASK   = 6'h3F;
	localparam logic [7:0] CHK_OFFSET = 8'h20;

	localparam logic [7:0] RST_LABEL_LEN = 8'd10;
	localparam logic [7:0] RST_STAMP_LEN = 8'd14;
	localparam logic [7:0] RST_VALUE_LEN = 8'd150;

	typedef enum logic [1:0] {
		REG_LABEL_LEN = 2'd0,
		REG_STAMP_LEN = 2'd1,
		REG_VALUE_LEN = 2'd2
	} reg_index_t;

	typedef enum logic [1:0] {
		ST_CONT = 2'd0,
		ST_OK   = 2'd1,
		ST_FAIL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		LS_IDLE,
		LS_OPEN,
		LS_BAD
	} line_state_t;

	typedef struct packed {
		logic [7:0] max_label_len;
		logic [7:0] max_stamp_len;
		logic [7:0] max_value_len;
	} cfg_t;

	typedef struct packed {
		status_t    status;
		logic       data_valid;
		logic [6:0] data_byte;
		logic [1:0] segment;
		logic       has_stamp;
	} res_t;

endpackage

// ===== design/mtlc_if.sv =====
// Valid/ready channel interfaces for the line checker request and result.
// Depends on nothing but the port widths of the block.
interface mtlc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;

	modport source (output valid, output byte_in, input ready);
	modport sink (input valid, input byte_in, output ready);
endinterface

interface mtlc_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic       data_valid;
	logic [6:0] data_byte;
	logic [1:0] segment;
	logic       has_stamp;

	modport source (output valid, output status, output data_valid, output data_byte,
		output segment, output has_stamp, input ready);
	modport sink (input valid, input status, input data_valid, input data_byte,
		input segment, input has_stamp, output ready);
endinterface

// ===== design/mtlc_cfg_regs.sv =====
// Limit registers of the line checker, written through a plain write port.
// Depends on mtlc_pkg.
module mtlc_cfg_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [7:0]         wr_data,
	output mtlc_pkg::cfg_t     cfg
);

	mtlc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_label_len <= mtlc_pkg::RST_LABEL_LEN;
			cfg_q.max_stamp_len <= mtlc_pkg::RST_STAMP_LEN;
			cfg_q.max_value_len <= mtlc_pkg::RST_VALUE_LEN;
		end else if (wr_en) begin
			unique case (wr_index)
				mtlc_pkg::REG_LABEL_LEN: cfg_q.max_label_len <= wr_data;
				mtlc_pkg::REG_STAMP_LEN: cfg_q.max_stamp_len <= wr_data;
				mtlc_pkg::REG_VALUE_LEN: cfg_q.max_value_len <= wr_data;
				default: ; // unmapped index: drop the write
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/mtlc_line_core.sv =====
// Per-character line state and result logic of the line checker.
// Depends on mtlc_pkg; state advances only when step is high.
module mtlc_line_core #(
	parameter int LINE_CAPACITY = mtlc_pkg::DEF_LINE_CAPACITY
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic [6:0]     ch,
	input  mtlc_pkg::cfg_t cfg,
	output mtlc_pkg::res_t res
);

	localparam int FILL_W = $clog2(LINE_CAPACITY);
	localparam int CMP_W  = (FILL_W > 8) ? FILL_W : 8;
	localparam logic [FILL_W-1:0] FULL_AT = FILL_W'(LINE_CAPACITY - 1);

	mtlc_pkg::line_state_t state_q, state_d;

	logic [FILL_W-1:0] fill_q, fill_d;
	logic [2:0]        sep_q, sep_d;
	logic [7:0]        sum_q, sum_d;
	logic [6:0]        first_q, first_d;
	logic [FILL_W-1:0] len_q [3];
	logic [FILL_W-1:0] len_d [3];
	logic [FILL_W-1:0] cur_q, cur_d;

	logic is_lf, is_cr, is_tab, is_abort;
	logic full, sep_ok, three, chk_ok, len_ok;
	logic [7:0] rest, chk;
	logic [FILL_W-1:0] stl, val;

	assign is_lf    = (ch == mtlc_pkg::CH_LF);
	assign is_cr    = (ch == mtlc_pkg::CH_CR);
	assign is_tab   = (ch == mtlc_pkg::CH_TAB);
	assign is_abort = (ch == mtlc_pkg::CH_STX) || (ch == mtlc_pkg::CH_ETX);

	assign full = (state_q == mtlc_pkg::LS_OPEN) && (fill_q >= FULL_AT);

	// checksum covers the line minus the first checksum byte itself
	assign rest   = sum_q - {1'b0, first_q};
	assign chk    = {2'b00, rest[5:0] & mtlc_pkg::CHK_MASK} + mtlc_pkg::CHK_OFFSET;
	assign chk_ok = (chk == {1'b0, first_q});

	assign sep_ok = (sep_q == 3'd2) || (sep_q == 3'd3);
	assign three  = (sep_q == 3'd3);
	assign stl    = three ? len_q[1] : '0;
	assign val    = three ? len_q[2] : len_q[1];
	assign len_ok = (CMP_W'(len_q[0]) <= CMP_W'(cfg.max_label_len))
		&& (CMP_W'(stl) <= CMP_W'(cfg.max_stamp_len))
		&& (CMP_W'(val) <= CMP_W'(cfg.max_value_len));

	// next line state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mtlc_pkg::LS_IDLE: begin
				if (is_lf) state_d = mtlc_pkg::LS_OPEN;
			end
			mtlc_pkg::LS_BAD: begin
				if (is_lf) state_d = mtlc_pkg::LS_OPEN;
			end
			mtlc_pkg::LS_OPEN: begin
				if (full) begin
					state_d = mtlc_pkg::LS_BAD;
				end else if (is_abort) begin
					state_d = mtlc_pkg::LS_IDLE;
				end else if (is_cr) begin
					state_d = (sep_ok && chk_ok) ? mtlc_pkg::LS_IDLE : mtlc_pkg::LS_BAD;
				end else if (is_tab && three) begin
					state_d = mtlc_pkg::LS_BAD;
				end
			end
			default: state_d = mtlc_pkg::LS_IDLE;
		endcase
	end

	// line counters and result
	always_comb begin
		fill_d  = fill_q;
		sep_d   = sep_q;
		sum_d   = sum_q;
		first_d = first_q;
		len_d   = len_q;
		cur_d   = cur_q;
		res     = '0;
		res.status = mtlc_pkg::ST_CONT;

		if (full) begin
			res.status = mtlc_pkg::ST_FAIL;
		end else if (is_lf || ((state_q == mtlc_pkg::LS_OPEN) && is_abort)) begin
			fill_d  = '0;
			sep_d   = '0;
			sum_d   = '0;
			first_d = '0;
			len_d   = '{default: '0};
			cur_d   = '0;
		end else if (state_q == mtlc_pkg::LS_OPEN) begin
			if (is_cr) begin
				if (sep_ok && chk_ok) begin
					res.status    = len_ok ? mtlc_pkg::ST_OK : mtlc_pkg::ST_FAIL;
					res.has_stamp = len_ok && three;
					fill_d  = '0;
					sep_d   = '0;
					sum_d   = '0;
					first_d = '0;
					len_d   = '{default: '0};
					cur_d   = '0;
				end else begin
					res.status = mtlc_pkg::ST_FAIL;
				end
			end else if (is_tab) begin
				sep_d  = sep_q + 3'd1;
				fill_d = fill_q + FILL_W'(1);
				sum_d  = sum_q + {1'b0, mtlc_pkg::CH_TAB};
				if (three) begin
					res.status = mtlc_pkg::ST_FAIL;
				end else begin
					for (int i = 0; i < 3; i++) begin
						if (sep_q[1:0] == 2'(i)) len_d[i] = cur_q;
					end
					cur_d   = '0;
					first_d = '0;
				end
			end else begin
				fill_d = fill_q + FILL_W'(1);
				sum_d  = sum_q + {1'b0, ch};
				if (cur_q == '0) first_d = ch;
				cur_d  = cur_q + FILL_W'(1);
				res.data_valid = 1'b1;
				res.data_byte  = ch;
				res.segment    = sep_q[1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mtlc_pkg::LS_IDLE;
			fill_q  <= '0;
			sep_q   <= '0;
			sum_q   <= '0;
			first_q <= '0;
			len_q   <= '{default: '0};
			cur_q   <= '0;
		end else if (step) begin
			state_q <= state_d;
			fill_q  <= fill_d;
			sep_q   <= sep_d;
			sum_q   <= sum_d;
			first_q <= first_d;
			len_q   <= len_d;
			cur_q   <= cur_d;
		end
	end

endmodule

// ===== design/meter_teleinfo_line_checker_top.sv =====
// Line checker for a metering serial stream: one character per request in,
// one result per request out. A line opens with LF and closes with CR; TAB
// splits label, optional timestamp, value and checksum; STX or ETX abort the
// line. Every content byte is echoed with its segment number, and CR reports
// the line ok (with a timestamp flag) or failed. A request is taken into an
// input register, evaluated in one pass of logic against the line state, and
// its result lands in an output register, so one request per clock is
// sustained while results are taken; an empty input register still accepts
// while a result waits downstream. Throughput stalls only when both registers
// are full and the result is not being taken. The three limit registers are
// written through wr_en/wr_index/wr_data; the user must do so only while the
// block is idle, which the block does not enforce. An index of 3 is ignored.
// No clearing pass runs after reset. Depends on mtlc_pkg, the channel interfaces, mtlc_cfg_regs and mtlc_line_core.
`include "meter_teleinfo_line_checker_top_defines.svh"

module meter_teleinfo_line_checker_top #(
	parameter int LINE_CAPACITY = mtlc_pkg::DEF_LINE_CAPACITY
) (
	input  logic        clk,
	input  logic        arst_n,
	mtlc_in_if.sink     in_ch,
	mtlc_out_if.source  out_ch,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [7:0]  wr_data
);

	mtlc_pkg::cfg_t cfg;
	mtlc_pkg::res_t res;

	logic       valid_s1;
	logic [6:0] byte_s1;
	logic       valid_s2;
	mtlc_pkg::res_t res_s2;

	logic adv_s2;
	logic step;

	// the result register frees up when empty or being taken this cycle
	assign adv_s2      = !valid_s2 || out_ch.ready;
	assign step        = valid_s1 && adv_s2;
	assign in_ch.ready = !valid_s1 || adv_s2;

	mtlc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	mtlc_line_core #(
		.LINE_CAPACITY (LINE_CAPACITY)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.ch     (byte_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// input register: hold the masked character until the core consumes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.byte_in[6:0] & mtlc_pkg::CHAR_MASK;
		end
	end

	// result register: advance on a free slot, otherwise hold for downstream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res;
		end
	end

	assign out_ch.valid      = valid_s2;
	assign out_ch.status     = res_s2.status;
	assign out_ch.data_valid = res_s2.data_valid;
	assign out_ch.data_byte  = res_s2.data_byte;
	assign out_ch.segment    = res_s2.segment;
	assign out_ch.has_stamp  = res_s2.has_stamp;

	// an echoed byte never comes with a line verdict
	`MTLC_ASSERT_NOW(a_echo_is_cont, clk, arst_n, valid_s2 && res_s2.data_valid, res_s2.status == mtlc_pkg::ST_CONT)
	// the timestamp flag only rides on a good line
	`MTLC_ASSERT_NOW(a_stamp_on_ok, clk, arst_n, valid_s2 && res_s2.has_stamp, res_s2.status == mtlc_pkg::ST_OK)
	// input backpressure only when both registers are occupied
	`MTLC_ASSERT_NOW(a_ready_low_full, clk, arst_n, !in_ch.ready, valid_s1 && valid_s2 && !out_ch.ready)
	// a character blocked in the input register stays there unchanged
	`MTLC_ASSERT_NEXT(a_s1_held, clk, arst_n, valid_s1 && !adv_s2, valid_s1 && $stable(byte_s1))

endmodule
